// ===== hw/rtl/svkp_pkg.sv =====
package svkp_pkg;

   localparam int BINS = 64;
   localparam int BIN_W = 6;
   localparam int KNOT_W = 4;
   localparam int SCORE_W = 40;
   localparam int IN_SCORE_W = 24;
   localparam int LAMBDA_W = 16;
   localparam int TAG_W = 4;
   localparam int CAND_W = 42;
   localparam int SQ_W = 14;
   localparam int PROD_W = LAMBDA_W + SQ_W;
   localparam int SCORE_AW = 13;
   localparam int PRED_AW = 16;
   localparam int SCORE_DEPTH = 8192;
   localparam int PRED_DEPTH = 57344;
   localparam int CNT_W = 13;

   localparam logic [KNOT_W-1:0] LAST_SEG = 4'd14;
   localparam logic [TAG_W-1:0] TAG_NONE = 4'd0;
   localparam logic [CNT_W-1:0] CLEAR_LAST = 13'd8191;
   localparam logic [11:0] LAYER_LAST = 12'd4095;
   localparam logic [1:0] DRAIN_LAST = 2'd3;
   localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 16'd614;
   localparam logic [BIN_W-1:0] MAXD_RST = 6'd8;
   localparam logic signed [CAND_W-1:0] MAX40 = 42'sh07F_FFFF_FFFF;
   localparam logic signed [CAND_W-1:0] MIN40 = -42'sh080_0000_0000;

   localparam logic [0:0] CSR_LAMBDA = 1'd0;
   localparam logic [0:0] CSR_MAXD = 1'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_ARGMAX,
      ST_ADRAIN,
      ST_FIN,
      ST_FIN2,
      ST_BISSUE,
      ST_BWAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic signed [SCORE_W-1:0] score;
   } score_word_type;

   typedef struct packed {
      logic issue;
      logic argmax;
      logic [11:0] idx;
   } eval_ctl_type;

endpackage

// ===== hw/rtl/svkp_score_ram.sv =====
module svkp_score_ram
   import svkp_pkg::*;
(
   input  logic                clock,
   input  logic                we,
   input  logic [SCORE_AW-1:0] waddr,
   input  score_word_type      wdata,
   input  logic                re,
   input  logic [SCORE_AW-1:0] raddr,
   output score_word_type      rdata
);

   score_word_type mem [0:SCORE_DEPTH-1];
   score_word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/svkp_pred_ram.sv =====
module svkp_pred_ram
   import svkp_pkg::*;
(
   input  logic               clock,
   input  logic               we,
   input  logic [PRED_AW-1:0] waddr,
   input  logic [BIN_W-1:0]   wdata,
   input  logic               re,
   input  logic [PRED_AW-1:0] raddr,
   output logic [BIN_W-1:0]   rdata
);

   logic [BIN_W-1:0] mem [0:PRED_DEPTH-1];
   logic [BIN_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/svkp_eval.sv =====
module svkp_eval
   import svkp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clr,
   input  eval_ctl_type                 ctl,
   input  score_word_type               rd,
   input  logic [TAG_W-1:0]             exp_tag,
   input  logic [LAMBDA_W-1:0]          lambda,
   input  logic [BIN_W-1:0]             from_bin,
   input  logic [BIN_W-1:0]             to_bin,
   input  logic [IN_SCORE_W-1:0]        item_score,
   output logic                         any,
   output logic signed [SCORE_W-1:0]    best,
   output logic [11:0]                  best_idx
);

   // stage 1: aligned with read data
   logic v1_ff, am1_ff;
   logic [11:0] idx1_ff;
   // stage 2: square registered
   logic v2_ff, am2_ff;
   logic [11:0] idx2_ff;
   logic signed [SCORE_W-1:0] sc2_ff;
   logic [SQ_W-1:0] sq2_ff;
   // stage 3: penalty product registered
   logic v3_ff, am3_ff;
   logic [11:0] idx3_ff;
   logic signed [SCORE_W-1:0] sc3_ff;
   logic [PROD_W-1:0] prod3_ff;
   // running best
   logic any_ff;
   logic signed [SCORE_W-1:0] best_ff;
   logic [11:0] best_idx_ff;

   logic signed [7:0] curv;
   logic signed [15:0] sq_full;
   logic match;
   logic [PROD_W:0] pen_sum;
   logic [CAND_W-1:0] pen;
   logic signed [CAND_W-1:0] cand_raw;
   logic signed [CAND_W-1:0] cand;
   logic upd;

   always_comb begin
      curv = $signed({2'b00, to_bin}) - $signed({1'b0, from_bin, 1'b0})
           + $signed({2'b00, idx1_ff[BIN_W-1:0]});
      sq_full = curv * curv;
      match = v1_ff && (rd.tag == exp_tag);
      pen_sum = {1'b0, prod3_ff} + (PROD_W+1)'(8);
      pen = CAND_W'(pen_sum >> 4);
      cand_raw = CAND_W'(sc3_ff) + $signed({{(CAND_W-IN_SCORE_W){1'b0}}, item_score})
               - $signed(pen);
      if (am3_ff) begin
         cand = CAND_W'(sc3_ff);
      end else if (cand_raw > MAX40) begin
         cand = MAX40;
      end else if (cand_raw < MIN40) begin
         cand = MIN40;
      end else begin
         cand = cand_raw;
      end
      upd = v3_ff && (!any_ff || (cand > CAND_W'(best_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.issue;
         v2_ff <= match;
         v3_ff <= v2_ff;
         if (clr) begin
            any_ff <= 1'b0;
         end else if (upd) begin
            any_ff <= 1'b1;
         end
      end
      am1_ff <= ctl.argmax;
      idx1_ff <= ctl.idx;
      am2_ff <= am1_ff;
      idx2_ff <= idx1_ff;
      sc2_ff <= rd.score;
      sq2_ff <= SQ_W'($unsigned(sq_full));
      am3_ff <= am2_ff;
      idx3_ff <= idx2_ff;
      sc3_ff <= sc2_ff;
      prod3_ff <= lambda * sq2_ff;
      if (upd) begin
         best_ff <= SCORE_W'(cand);
         best_idx_ff <= idx3_ff;
      end
   end

   assign any = any_ff;
   assign best = best_ff;
   assign best_idx = best_idx_ff;

endmodule

// ===== hw/rtl/second_order_viterbi_knot_path_top.sv =====
// Knot path search over height bins, one segment score per request.
// Request channel: present req_* with start; a request transfers at a clock
// edge with start high and busy low. Items arrive in segment order; segment 0
// seeds the first layer, later segments relax against the previous layer.
// After the transfer a dropped item is not processed, a segment 0 item goes
// straight to the write state, and a later item first scans, with one score
// memory read per predecessor bin (17 reads at the default window, fewer
// near the edge bins), then drains the evaluation pipeline and writes once.
// An item with last set then runs an argmax sweep over all 4096 words of the
// final layer, drains the evaluation pipeline, seeds the path (FIN, FIN2),
// backtracks through the predecessor memory (BISSUE, BWAIT per knot), and
// emits one result per knot on rsp_* with rsp_valid high for one cycle each,
// knot 0 first; rsp_path_end marks the last one. The receiver cannot stall,
// so results go out back to back.
// After reset and after each path emission a clearing pass marks all 8192
// score memory words empty, one per cycle; busy stays high during it.
// Configuration: csr_index 0 is the curvature weight, 1 is the bin window;
// csr_ready is high only while idle with start low, so a write never
// overlaps an item.
module second_order_viterbi_knot_path_top
   import svkp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [KNOT_W-1:0]         req_segment,
   input  logic [BIN_W-1:0]          req_from_bin,
   input  logic [BIN_W-1:0]          req_to_bin,
   input  logic [IN_SCORE_W-1:0]     req_score,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic [KNOT_W-1:0]         rsp_knot,
   output logic [BIN_W-1:0]          rsp_bin,
   output logic signed [SCORE_W-1:0] rsp_total_score,
   output logic                      rsp_found,
   output logic                      rsp_path_end,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  logic [LAMBDA_W-1:0]       csr_wdata
);

   state_type state_ff, state_in;

   // configuration
   logic [LAMBDA_W-1:0] lambda_ff;
   logic [BIN_W-1:0]    maxd_ff;

   // held request and sequencing registers
   logic [KNOT_W-1:0]     seg_ff, seg_in;
   logic [BIN_W-1:0]      b_ff, b_in;
   logic [BIN_W-1:0]      c_ff, c_in;
   logic [IN_SCORE_W-1:0] score_ff, score_in;
   logic                  last_ff, last_in;
   logic [KNOT_W-1:0]     cur_ff, cur_in;
   logic [BIN_W-1:0]      a_ff, a_in;
   logic [BIN_W-1:0]      hi_ff, hi_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   // backtrack: knot k, bin at k, bin at k-1
   logic [KNOT_W-1:0]     pk_ff, pk_in;
   logic [BIN_W-1:0]      ph_ff, ph_in;
   logic [BIN_W-1:0]      pm_ff, pm_in;
   logic [BIN_W-1:0]      path_ff [0:(1<<KNOT_W)-1];

   logic                  path_we;
   logic [KNOT_W-1:0]     path_waddr;
   logic [BIN_W-1:0]      path_wdata;

   // request decode
   logic [BIN_W-1:0] diff;
   logic [BIN_W:0]   lo_w, hi_w;
   logic             proc;
   logic             accept;
   logic [KNOT_W-1:0] end_k;

   // memory ports
   logic                s_we, s_re;
   logic [SCORE_AW-1:0] s_waddr, s_raddr;
   score_word_type      s_wdata, s_rdata;
   logic                p_we, p_re;
   logic [PRED_AW-1:0]  p_waddr, p_raddr;
   logic [BIN_W-1:0]    p_wdata, p_rdata;

   eval_ctl_type              ev_ctl;
   logic                      ev_clr;
   logic [TAG_W-1:0]          ev_tag;
   logic                      ev_any;
   logic signed [SCORE_W-1:0] ev_best;
   logic [11:0]               ev_idx;

   svkp_score_ram u_score_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   svkp_pred_ram u_pred_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .re    (p_re),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   svkp_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .clr        (ev_clr),
      .ctl        (ev_ctl),
      .rd         (s_rdata),
      .exp_tag    (ev_tag),
      .lambda     (lambda_ff),
      .from_bin   (b_ff),
      .to_bin     (c_ff),
      .item_score (score_ff),
      .any        (ev_any),
      .best       (ev_best),
      .best_idx   (ev_idx)
   );

   // decode the incoming pair: window check and segment order
   always_comb begin
      diff = (req_from_bin > req_to_bin) ? (req_from_bin - req_to_bin)
                                         : (req_to_bin - req_from_bin);
      lo_w = (req_from_bin > maxd_ff) ? {1'b0, req_from_bin - maxd_ff} : '0;
      hi_w = {1'b0, req_from_bin} + {1'b0, maxd_ff};
      if (hi_w > (BIN_W+1)'(BINS - 1)) begin
         hi_w = (BIN_W+1)'(BINS - 1);
      end
      proc = (req_segment <= LAST_SEG) && (diff <= maxd_ff)
          && ((req_segment == cur_ff) || (req_segment == cur_ff + 4'd1));
      accept = start && (state_ff == ST_IDLE);
      end_k = cur_ff + 4'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CLEAR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               priority if (proc && req_segment == '0) state_in = ST_WRITE;
               else if (proc) state_in = ST_SCAN;
               else if (req_last) state_in = ST_ARGMAX;
               else state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (a_ff == hi_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (cnt_ff[1:0] == DRAIN_LAST) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = last_ff ? ST_ARGMAX : ST_IDLE;
         end
         ST_ARGMAX: begin
            if (cnt_ff[11:0] == LAYER_LAST) state_in = ST_ADRAIN;
         end
         ST_ADRAIN: begin
            if (cnt_ff[1:0] == DRAIN_LAST) state_in = ev_any ? ST_FIN : ST_EMIT;
         end
         ST_FIN: begin
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            state_in = (pk_ff >= 4'd2) ? ST_BISSUE : ST_EMIT;
         end
         ST_BISSUE: begin
            state_in = ST_BWAIT;
         end
         ST_BWAIT: begin
            state_in = (pk_ff >= 4'd3) ? ST_BISSUE : ST_EMIT;
         end
         ST_EMIT: begin
            if (cnt_ff[KNOT_W-1:0] == end_k) state_in = ST_CLEAR;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      seg_in = seg_ff;
      b_in = b_ff;
      c_in = c_ff;
      score_in = score_ff;
      last_in = last_ff;
      cur_in = cur_ff;
      a_in = a_ff;
      hi_in = hi_ff;
      cnt_in = cnt_ff;
      pk_in = pk_ff;
      ph_in = ph_ff;
      pm_in = pm_ff;
      path_we = 1'b0;
      path_waddr = pk_ff;
      path_wdata = ph_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = (cnt_ff == CLEAR_LAST) ? '0 : cnt_ff + 13'd1;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               seg_in = req_segment;
               b_in = req_from_bin;
               c_in = req_to_bin;
               score_in = req_score;
               last_in = req_last;
               a_in = lo_w[BIN_W-1:0];
               hi_in = hi_w[BIN_W-1:0];
               if (proc) cur_in = req_segment;
            end
         end
         ST_SCAN: begin
            a_in = a_ff + 6'd1;
            cnt_in = '0;
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff + 13'd1;
         end
         ST_WRITE: begin
            cnt_in = '0;
         end
         ST_ARGMAX: begin
            cnt_in = (cnt_ff[11:0] == LAYER_LAST) ? '0 : cnt_ff + 13'd1;
         end
         ST_ADRAIN: begin
            cnt_in = (cnt_ff[1:0] == DRAIN_LAST) ? '0 : cnt_ff + 13'd1;
            pk_in = end_k;
            ph_in = ev_idx[BIN_W-1:0];
            pm_in = ev_idx[11:BIN_W];
         end
         ST_FIN: begin
            path_we = 1'b1;
            path_waddr = pk_ff;
            path_wdata = ph_ff;
         end
         ST_FIN2: begin
            path_we = 1'b1;
            path_waddr = pk_ff - 4'd1;
            path_wdata = pm_ff;
         end
         ST_BISSUE: begin
         end
         ST_BWAIT: begin
            // step back one knot: predecessor becomes the new left bin
            path_we = 1'b1;
            path_waddr = pk_ff - 4'd2;
            path_wdata = p_rdata;
            ph_in = pm_ff;
            pm_in = p_rdata;
            pk_in = pk_ff - 4'd1;
         end
         ST_EMIT: begin
            if (cnt_ff[KNOT_W-1:0] == end_k) begin
               cnt_in = '0;
               cur_in = '0;
            end else begin
               cnt_in = cnt_ff + 13'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // memory, evaluator and port controls
   always_comb begin
      s_we = 1'b0;
      s_waddr = cnt_ff;
      s_wdata.tag = TAG_NONE;
      s_wdata.score = '0;
      s_re = 1'b0;
      s_raddr = {seg_ff[0], a_ff, b_ff};
      p_we = 1'b0;
      p_waddr = {seg_ff - 4'd1, b_ff, c_ff};
      p_wdata = ev_idx[BIN_W-1:0];
      p_re = 1'b0;
      p_raddr = {pk_ff - 4'd2, pm_ff, ph_ff};
      ev_ctl.issue = 1'b0;
      ev_ctl.argmax = 1'b0;
      ev_ctl.idx = {6'd0, a_ff};
      ev_clr = 1'b0;
      ev_tag = cur_ff;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            s_we = 1'b1;
         end
         ST_IDLE: begin
            ev_clr = 1'b1;
         end
         ST_SCAN: begin
            s_re = 1'b1;
            ev_ctl.issue = 1'b1;
         end
         ST_WRITE: begin
            // segment 0 seeds; later segments write only a reachable pair
            ev_clr = 1'b1;
            s_waddr = {~seg_ff[0], b_ff, c_ff};
            s_wdata.tag = seg_ff + 4'd1;
            if (seg_ff == '0) begin
               s_we = 1'b1;
               s_wdata.score = SCORE_W'(score_ff);
            end else begin
               s_we = ev_any;
               s_wdata.score = ev_best;
               p_we = ev_any;
            end
         end
         ST_ARGMAX: begin
            s_re = 1'b1;
            s_raddr = {end_k[0], cnt_ff[11:0]};
            ev_ctl.issue = 1'b1;
            ev_ctl.argmax = 1'b1;
            ev_ctl.idx = cnt_ff[11:0];
            ev_tag = end_k;
         end
         ST_ADRAIN: begin
            ev_tag = end_k;
         end
         ST_BISSUE: begin
            p_re = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   // take a register write only between items, never beside a request
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_knot = cnt_ff[KNOT_W-1:0];
   assign rsp_bin = ev_any ? path_ff[cnt_ff[KNOT_W-1:0]] : '0;
   assign rsp_total_score = ev_any ? ev_best : '0;
   assign rsp_found = ev_any;
   assign rsp_path_end = (cnt_ff[KNOT_W-1:0] == end_k);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cur_ff <= '0;
         cnt_ff <= '0;
         lambda_ff <= LAMBDA_RST;
         maxd_ff <= MAXD_RST;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         cnt_ff <= cnt_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LAMBDA: lambda_ff <= csr_wdata;
               CSR_MAXD:   maxd_ff <= csr_wdata[BIN_W-1:0];
               default:    lambda_ff <= lambda_ff;
            endcase
         end
      end
      seg_ff <= seg_in;
      b_ff <= b_in;
      c_ff <= c_in;
      score_ff <= score_in;
      last_ff <= last_in;
      a_ff <= a_in;
      hi_ff <= hi_in;
      pk_ff <= pk_in;
      ph_ff <= ph_in;
      pm_ff <= pm_in;
      if (path_we) begin
         path_ff[path_waddr] <= path_wdata;
      end
   end

endmodule
